// ===== rtl/png_unf_pkg.sv =====
`timescale 1ns / 1ps
// Package: shared types, constants and the Paeth predictor for the scanline unfilter.
package png_unf_pkg;

	localparam int BYTES_PER_PIXEL   = 4;
	localparam int DEF_MAX_WIDTH     = 4096;
	localparam int MAX_HEIGHT        = 4096;
	localparam int CFG_W             = 13;
	localparam int ROW_W             = 12;
	localparam int ITEM_QUEUE_DEPTH  = 4;

	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4
	} filt_t;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} cfg_reg_t;

	// per-request control between front and back
	typedef struct packed {
		logic  is_err;
		logic  first_row;
		filt_t filter;
		logic  last_col;
		logic  last_row;
	} item_ctrl_t;

	localparam int CTRL_W = $bits(item_ctrl_t);

	function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		logic signed [9:0] p;
		logic signed [9:0] da;
		logic signed [9:0] db;
		logic signed [9:0] dc;
		logic signed [9:0] pa;
		logic signed [9:0] pb;
		logic signed [9:0] pc;
		logic [7:0] pick;
		p  = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({2'b00, c});
		da = p - $signed({2'b00, a});
		db = p - $signed({2'b00, b});
		dc = p - $signed({2'b00, c});
		pa = (da < 0) ? -da : da;
		pb = (db < 0) ? -db : db;
		pc = (dc < 0) ? -dc : dc;
		if (pa <= pb && pa <= pc) begin
			pick = a;
		end else if (pb <= pc) begin
			pick = b;
		end else begin
			pick = c;
		end
		return pick;
	endfunction

endpackage

// ===== rtl/png_scanline_unfilter_rgba8_top.sv =====
`timescale 1ns / 1ps
// Top level: PNG scanline unfilter for 8-bit RGBA, front/queue/back.
// Path: a sample byte's request passes the item queue and stage s1 into the output buffer,
// where it can be popped. Throughput: one byte per cycle unless the output buffer is full,
// set by the single write and read port of the line store. Filter-type bytes give no result
// unless the type is bad. Reset clears counters, queues and config (width 1, height 1); the
// line store is not cleared, since row 0 does not use what it reads from it.
module png_scanline_unfilter_rgba8_top import png_unf_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             push,
	output logic             full,
	input  logic [7:0]       stream_byte,
	output logic             empty,
	input  logic             pop,
	output logic [7:0]       sample_byte,
	output logic [1:0]       channel_index,
	output logic             row_end,
	output logic             image_end,
	output logic             bad_filter
);

	localparam int COL_W = $clog2(MAX_WIDTH * BYTES_PER_PIXEL);
	localparam int QW    = CTRL_W + COL_W + 8;

	logic             fq_wr;
	item_ctrl_t       fq_ctrl;
	logic [COL_W-1:0] fq_col;
	logic [7:0]       fq_byte;
	logic             fq_full;
	logic             bq_rd;
	logic             bq_valid;
	logic [QW-1:0]    bq_data;
	item_ctrl_t       bq_ctrl;
	logic [COL_W-1:0] bq_col;
	logic [7:0]       bq_byte;

	png_unf_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.COL_W    (COL_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.full       (full),
		.stream_byte(stream_byte),
		.q_wr       (fq_wr),
		.q_ctrl     (fq_ctrl),
		.q_col      (fq_col),
		.q_byte     (fq_byte),
		.q_full     (fq_full)
	);

	png_unf_queue #(
		.W    (QW),
		.DEPTH(ITEM_QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (fq_wr),
		.wdata ({fq_ctrl, fq_col, fq_byte}),
		.full  (fq_full),
		.rd    (bq_rd),
		.rdata (bq_data),
		.valid (bq_valid)
	);

	assign bq_ctrl = item_ctrl_t'(bq_data[QW-1 -: CTRL_W]);
	assign bq_col  = bq_data[8 +: COL_W];
	assign bq_byte = bq_data[7:0];

	png_unf_back #(
		.MAX_WIDTH(MAX_WIDTH),
		.COL_W    (COL_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (bq_valid),
		.q_ctrl       (bq_ctrl),
		.q_col        (bq_col),
		.q_byte       (bq_byte),
		.q_rd         (bq_rd),
		.empty        (empty),
		.pop          (pop),
		.sample_byte  (sample_byte),
		.channel_index(channel_index),
		.row_end      (row_end),
		.image_end    (image_end),
		.bad_filter   (bad_filter)
	);

endmodule

// ===== rtl/png_unf_queue.sv =====
`timescale 1ns / 1ps
// Small synchronous FIFO that decouples the front and back parts.
module png_unf_queue import png_unf_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = ITEM_QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         valid
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign valid = (cnt_q != '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(wr && full))
		else $error("queue write while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(rd && !valid))
		else $error("queue read while empty");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue count out of range");

endmodule

// ===== rtl/png_unf_front.sv =====
`timescale 1ns / 1ps
// Front part: config registers, row/column tracking and request classification.
module png_unf_front import png_unf_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int COL_W     = $clog2(MAX_WIDTH * BYTES_PER_PIXEL)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             push,
	output logic             full,
	input  logic [7:0]       stream_byte,
	output logic             q_wr,
	output item_ctrl_t       q_ctrl,
	output logic [COL_W-1:0] q_col,
	output logic [7:0]       q_byte,
	input  logic             q_full
);

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	filt_t            filt_q;
	logic             await_q;
	logic             drop_q;

	logic [13:0]      wclamp;
	logic [15:0]      row_bytes;
	logic [CFG_W-1:0] hclamp;
	logic             accept;
	logic             last_col;
	logic             last_row;
	logic             bad_type;

	assign full   = q_full;
	assign accept = push && !q_full;

	always_comb begin
		wclamp = {1'b0, width_q};
		if (width_q == '0) begin
			wclamp = 14'd1;
		end else if ({1'b0, width_q} > 14'(MAX_WIDTH)) begin
			wclamp = 14'(MAX_WIDTH);
		end
		row_bytes = {wclamp, 2'b00};
		hclamp = height_q;
		if (height_q == '0) begin
			hclamp = CFG_W'(1);
		end else if (height_q > CFG_W'(MAX_HEIGHT)) begin
			hclamp = CFG_W'(MAX_HEIGHT);
		end
		last_col = (16'(col_q) + 16'd1) >= row_bytes;
		last_row = ({1'b0, row_q} + 13'd1) >= hclamp;
		bad_type = stream_byte > {5'b0, FILT_PAETH};
	end

	always_comb begin
		q_wr             = 1'b0;
		q_ctrl.is_err    = 1'b0;
		q_ctrl.first_row = (row_q == '0);
		q_ctrl.filter    = filt_q;
		q_ctrl.last_col  = last_col;
		q_ctrl.last_row  = last_row;
		q_col            = col_q;
		q_byte           = stream_byte;
		if (accept && !drop_q) begin
			if (await_q) begin
				if (bad_type) begin
					q_wr          = 1'b1;
					q_ctrl.is_err = 1'b1;
				end
			end else begin
				q_wr = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(1);
			height_q <= CFG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default:    width_q  <= width_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			filt_q  <= FILT_NONE;
			await_q <= 1'b1;
			drop_q  <= 1'b0;
		end else if (accept) begin
			if (await_q) begin
				await_q <= 1'b0;
				col_q   <= '0;
				if (!drop_q) begin
					if (bad_type) begin
						drop_q <= 1'b1;
					end else begin
						filt_q <= filt_t'(stream_byte[2:0]);
					end
				end
			end else if (last_col) begin
				await_q <= 1'b1;
				col_q   <= '0;
				if (last_row) begin
					row_q  <= '0;
					drop_q <= 1'b0;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	a_err_sets_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(q_wr && q_ctrl.is_err) |=> drop_q)
		else $error("error request did not start dropping");
	a_no_push_dropping: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q |-> !q_wr)
		else $error("request issued while dropping");
	a_err_only_on_filter: assert property (@(posedge clk) disable iff (!arst_n)
		(q_wr && q_ctrl.is_err) |-> await_q)
		else $error("error request on a sample byte");

endmodule

// ===== rtl/png_unf_back.sv =====
`timescale 1ns / 1ps
// Back part: line store, reconstruction datapath and output buffer.
module png_unf_back import png_unf_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int COL_W     = $clog2(MAX_WIDTH * BYTES_PER_PIXEL)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  item_ctrl_t       q_ctrl,
	input  logic [COL_W-1:0] q_col,
	input  logic [7:0]       q_byte,
	output logic             q_rd,
	output logic             empty,
	input  logic             pop,
	output logic [7:0]       sample_byte,
	output logic [1:0]       channel_index,
	output logic             row_end,
	output logic             image_end,
	output logic             bad_filter
);

	localparam int STORE_DEPTH = MAX_WIDTH * BYTES_PER_PIXEL;

	logic [7:0]       line_mem [STORE_DEPTH];

	logic             vld_s1;
	item_ctrl_t       ctrl_s1;
	logic [COL_W-1:0] col_s1;
	logic [7:0]       byte_s1;
	logic [7:0]       up_s1;
	logic [31:0]      left_q;
	logic [31:0]      upleft_q;

	logic [7:0]       ob_data_q  [2];
	logic [1:0]       ob_chan_q  [2];
	logic             ob_rend_q  [2];
	logic             ob_iend_q  [2];
	logic             ob_bad_q   [2];
	logic             ob_wptr_q;
	logic             ob_rptr_q;
	logic [1:0]       ob_cnt_q;

	logic             ob_pop;
	logic             adv_s1;
	logic             past_first;
	logic [7:0]       left;
	logic [7:0]       up;
	logic [7:0]       upleft;
	logic [8:0]       avg_sum;
	logic [7:0]       pred;
	logic [7:0]       res;
	logic             smp_done;

	assign ob_pop   = pop && (ob_cnt_q != 2'd0);
	assign adv_s1   = vld_s1 && (ob_cnt_q != 2'd2);
	assign q_rd     = q_valid && (!vld_s1 || adv_s1);
	assign smp_done = adv_s1 && !ctrl_s1.is_err;

	always_comb begin
		past_first = 16'(col_s1) >= 16'(BYTES_PER_PIXEL);
		left       = past_first ? left_q[31:24] : 8'h00;
		up         = ctrl_s1.first_row ? 8'h00 : up_s1;
		upleft     = (!ctrl_s1.first_row && past_first) ? upleft_q[31:24] : 8'h00;
		avg_sum    = {1'b0, left} + {1'b0, up};
		case (ctrl_s1.filter)
			FILT_SUB:   pred = left;
			FILT_UP:    pred = up;
			FILT_AVG:   pred = avg_sum[8:1];
			FILT_PAETH: pred = paeth_pick(left, up, upleft);
			default:    pred = 8'h00;
		endcase
		res = byte_s1 + pred;
	end

	always_ff @(posedge clk) begin
		if (smp_done) begin
			line_mem[col_s1] <= res;
		end
		if (q_rd) begin
			up_s1 <= line_mem[q_col];
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			ctrl_s1 <= q_ctrl;
			col_s1  <= q_col;
			byte_s1 <= q_byte;
		end
		if (adv_s1) begin
			ob_data_q[ob_wptr_q] <= ctrl_s1.is_err ? 8'h00 : res;
			ob_chan_q[ob_wptr_q] <= ctrl_s1.is_err ? 2'd0 : col_s1[1:0];
			ob_rend_q[ob_wptr_q] <= !ctrl_s1.is_err && ctrl_s1.last_col;
			ob_iend_q[ob_wptr_q] <= !ctrl_s1.is_err && ctrl_s1.last_col && ctrl_s1.last_row;
			ob_bad_q[ob_wptr_q]  <= ctrl_s1.is_err;
		end
		if (smp_done) begin
			left_q   <= {left_q[23:0], res};
			upleft_q <= {upleft_q[23:0], up};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			ob_wptr_q <= 1'b0;
			ob_rptr_q <= 1'b0;
			ob_cnt_q  <= 2'd0;
		end else begin
			if (q_rd) begin
				vld_s1 <= 1'b1;
			end else if (adv_s1) begin
				vld_s1 <= 1'b0;
			end
			if (adv_s1) begin
				ob_wptr_q <= ~ob_wptr_q;
			end
			if (ob_pop) begin
				ob_rptr_q <= ~ob_rptr_q;
			end
			case ({adv_s1, ob_pop})
				2'b10:   ob_cnt_q <= ob_cnt_q + 2'd1;
				2'b01:   ob_cnt_q <= ob_cnt_q - 2'd1;
				default: ob_cnt_q <= ob_cnt_q;
			endcase
		end
	end

	assign empty         = (ob_cnt_q == 2'd0);
	assign sample_byte   = ob_data_q[ob_rptr_q];
	assign channel_index = ob_chan_q[ob_rptr_q];
	assign row_end       = ob_rend_q[ob_rptr_q];
	assign image_end     = ob_iend_q[ob_rptr_q];
	assign bad_filter    = ob_bad_q[ob_rptr_q];

	a_ob_range: assert property (@(posedge clk) disable iff (!arst_n) ob_cnt_q != 2'd3)
		else $error("output buffer count out of range");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && bad_filter) |-> (sample_byte == 8'h00 && !row_end && !image_end))
		else $error("error result carries data");
	a_iend_rend: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && image_end) |-> row_end)
		else $error("image end without row end");
	a_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !adv_s1) |=> (vld_s1 && $stable(col_s1) && $stable(byte_s1)))
		else $error("stalled request lost");

endmodule

// ===== tb/png_scanline_unfilter_rgba8_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench: PNG RGBA8 scanline unfilter, checked byte by byte against an in-bench predictor.
module png_scanline_unfilter_rgba8_top_tb;
	import png_unf_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int LINE_BYTES  = DEF_MAX_WIDTH * BYTES_PER_PIXEL;

	typedef struct packed {
		logic [7:0] sample;
		logic [1:0] channel;
		logic       row_last;
		logic       image_last;
		logic       bad;
	} sample_out_t;

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             cfg_we      = 1'b0;
	logic             cfg_index   = 1'b0;
	logic [CFG_W-1:0] cfg_data    = '0;
	logic             push        = 1'b0;
	logic             full;
	logic [7:0]       stream_byte = '0;
	logic             empty;
	logic             pop         = 1'b0;
	logic [7:0]       sample_byte;
	logic [1:0]       channel_index;
	logic             row_end;
	logic             image_end;
	logic             bad_filter;

	// predictor state
	logic [CFG_W-1:0] cfg_width       = 13'd1;
	logic [CFG_W-1:0] cfg_height      = 13'd1;
	bit   [7:0]       line_mem [0:LINE_BYTES-1];
	logic [31:0]      left_hist       = '0;
	logic [31:0]      upleft_hist     = '0;
	int               col_pos         = 0;
	int               row_num         = 0;
	filt_t            row_filter      = FILT_NONE;
	bit               awaiting_filter = 1'b1;
	bit               dropping        = 1'b0;

	sample_out_t      pending_bytes [$];
	sample_out_t      want;
	int               useful_items = 0;
	int               fail_count   = 0;
	int               send_idle    = 0;
	int               recv_idle    = 0;
	int               stall_cycles = 0;

	png_scanline_unfilter_rgba8_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.push         (push),
		.full         (full),
		.stream_byte  (stream_byte),
		.empty        (empty),
		.pop          (pop),
		.sample_byte  (sample_byte),
		.channel_index(channel_index),
		.row_end      (row_end),
		.image_end    (image_end),
		.bad_filter   (bad_filter)
	);

	always #5 clk = ~clk;

	function automatic int paeth_choose(input int a, input int b, input int c);
		int p;
		int da;
		int db;
		int dc;
		p  = a + b - c;
		da = (p > a) ? p - a : a - p;
		db = (p > b) ? p - b : b - p;
		dc = (p > c) ? p - c : c - p;
		if (da <= db && da <= dc)
			return a;
		if (db <= dc)
			return b;
		return c;
	endfunction

	task automatic add_expected(input sample_out_t r);
		pending_bytes = {pending_bytes, r};
	endtask

	task automatic unfilter_step(input logic [7:0] b);
		int          w;
		int          h;
		int          left;
		int          up;
		int          upleft;
		int          pred;
		logic [7:0]  res;
		bit          last_col;
		bit          last_row;
		sample_out_t r;
		w = cfg_width;
		h = cfg_height;
		if (w < 1) w = 1;
		if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
		if (h < 1) h = 1;
		if (h > MAX_HEIGHT) h = MAX_HEIGHT;
		if (!dropping)
			useful_items++;
		if (awaiting_filter) begin
			awaiting_filter = 1'b0;
			col_pos = 0;
			left_hist = '0;
			upleft_hist = '0;
			if (!dropping) begin
				if (b > FILT_PAETH) begin
					dropping = 1'b1;
					r = '0;
					r.bad = 1'b1;
					add_expected(r);
				end else begin
					row_filter = filt_t'(b[2:0]);
				end
			end
		end else begin
			last_col = (col_pos + 1) >= w * BYTES_PER_PIXEL;
			last_row = (row_num + 1) >= h;
			if (!dropping) begin
				left = (col_pos >= BYTES_PER_PIXEL) ? int'(left_hist[31:24]) : 0;
				up = 0;
				upleft = 0;
				if (row_num != 0) begin
					up = line_mem[col_pos];
					upleft = (col_pos >= BYTES_PER_PIXEL) ? int'(upleft_hist[31:24]) : 0;
				end
				case (row_filter)
					FILT_SUB:   pred = left;
					FILT_UP:    pred = up;
					FILT_AVG:   pred = (left + up) >> 1;
					FILT_PAETH: pred = paeth_choose(left, up, upleft);
					default:    pred = 0;
				endcase
				res = 8'(int'(b) + pred);
				left_hist = {left_hist[23:0], res};
				upleft_hist = {upleft_hist[23:0], 8'(up)};
				line_mem[col_pos] = res;
				r.sample = res;
				r.channel = 2'(col_pos);
				r.row_last = last_col;
				r.image_last = last_col && last_row;
				r.bad = 1'b0;
				add_expected(r);
			end
			if (last_col) begin
				awaiting_filter = 1'b1;
				col_pos = 0;
				if (last_row) begin
					row_num = 0;
					dropping = 1'b0;
				end else begin
					row_num = (row_num + 1) & 12'hfff;
				end
			end else begin
				col_pos = (col_pos + 1) & 14'h3fff;
			end
		end
	endtask

	task automatic send_byte(input logic [7:0] value);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		stream_byte <= value;
		@(posedge clk);
		while (full)
			@(posedge clk);
		unfilter_step(value);
	endtask

	task automatic send_random_byte();
		logic [7:0] v;
		if (awaiting_filter)
			v = ($urandom_range(99) < 4) ? 8'($urandom_range(255, 5)) : 8'($urandom_range(4, 0));
		else
			v = 8'($urandom_range(255));
		send_byte(v);
	endtask

	task automatic send_items(input int n);
		for (int i = 0; i < n; i++)
			send_random_byte();
	endtask

	task automatic drain_pipeline();
		push <= 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// runs to the end of the current image
	task automatic send_image(input bit allow_pause);
		do begin
			if (allow_pause && $urandom_range(49) == 0)
				drain_pipeline();
			send_random_byte();
		end while (!(awaiting_filter && row_num == 0));
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		if (idx == REG_WIDTH)
			cfg_width = value;
		else
			cfg_height = value;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_bad_filter();
		logic [7:0] seq [15] = '{8'h05, 8'h11, 8'h22, 8'h33, 8'h44,
			8'hff, 8'h00, 8'hff, 8'h00, 8'hff,
			8'(FILT_NONE), 8'ha5, 8'h5a, 8'hc3, 8'h3c};
		foreach (seq[i])
			send_byte(seq[i]);
	endtask

	task automatic test_directed_filters();
		logic [7:0] seq [25] = '{
			8'(FILT_NONE),  8'hff, 8'h00, 8'h80, 8'h7f,
			8'(FILT_SUB),   8'hff, 8'h01, 8'h00, 8'h80,
			8'(FILT_UP),    8'h01, 8'hff, 8'h80, 8'h00,
			8'(FILT_AVG),   8'hff, 8'hff, 8'h01, 8'h80,
			8'(FILT_PAETH), 8'h00, 8'hff, 8'h7f, 8'h81};
		drain_pipeline();
		write_reg(REG_WIDTH, 13'd1);
		write_reg(REG_HEIGHT, 13'd5);
		foreach (seq[i])
			send_byte(seq[i]);
	endtask

	task automatic test_random(input int n_items);
		int start;
		int pick;
		start = useful_items;
		while (useful_items - start < n_items) begin
			drain_pipeline();
			pick = $urandom_range(19);
			write_reg(REG_WIDTH, CFG_W'((pick == 0) ? 0 : (pick == 1) ?
				$urandom_range(24, 5) : $urandom_range(4, 1)));
			write_reg(REG_HEIGHT, CFG_W'(($urandom_range(19) == 0) ? 0 :
				$urandom_range(4, 1)));
			send_image(1'b1);
		end
	endtask

	// out-of-range and zero register values; long images are cut short by a mid-image write
	task automatic test_config_extremes();
		drain_pipeline();
		write_reg(REG_WIDTH, 13'd8191);
		write_reg(REG_HEIGHT, 13'd1);
		send_byte(8'(FILT_SUB));
		send_items(40);
		drain_pipeline();
		write_reg(REG_WIDTH, 13'd2);
		send_image(1'b0);
		drain_pipeline();
		write_reg(REG_WIDTH, 13'd1);
		write_reg(REG_HEIGHT, 13'd8191);
		send_items(15);
		drain_pipeline();
		write_reg(REG_HEIGHT, 13'd2);
		send_image(1'b0);
		drain_pipeline();
		write_reg(REG_WIDTH, 13'd0);
		write_reg(REG_HEIGHT, 13'd0);
		send_image(1'b0);
		send_image(1'b0);
	endtask

	// line store columns read here were all written by earlier rows
	task automatic test_midimage_config();
		drain_pipeline();
		write_reg(REG_WIDTH, 13'd3);
		write_reg(REG_HEIGHT, 13'd3);
		send_items(31);
		drain_pipeline();
		write_reg(REG_WIDTH, 13'd2);
		send_image(1'b0);
		drain_pipeline();
		write_reg(REG_HEIGHT, 13'd4);
		send_items(12);
		drain_pipeline();
		write_reg(REG_WIDTH, 13'd4);
		write_reg(REG_HEIGHT, 13'd2);
		send_image(1'b0);
		drain_pipeline();
		write_reg(REG_WIDTH, 13'd2);
		write_reg(REG_HEIGHT, 13'd5);
		send_items(25);
		drain_pipeline();
		write_reg(REG_HEIGHT, 13'd1);
		send_image(1'b0);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			pop <= ($urandom_range(99) >= recv_idle);
			if (pop && !empty) begin
				if (pending_bytes.size() == 0) begin
					$error("result popped with no request pending");
					fail_count++;
				end else begin
					want = pending_bytes.pop_front();
					if (sample_byte !== want.sample) begin
						$error("sample_byte: expected %0h, got %0h", want.sample, sample_byte);
						fail_count++;
					end
					if (channel_index !== want.channel) begin
						$error("channel_index: expected %0d, got %0d", want.channel,
							channel_index);
						fail_count++;
					end
					if (row_end !== want.row_last) begin
						$error("row_end: expected %0b, got %0b", want.row_last, row_end);
						fail_count++;
					end
					if (image_end !== want.image_last) begin
						$error("image_end: expected %0b, got %0b", want.image_last, image_end);
						fail_count++;
					end
					if (bad_filter !== want.bad) begin
						$error("bad_filter: expected %0b, got %0b", want.bad, bad_filter);
						fail_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("[png_scanline_unfilter_rgba8_top] ERROR");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 19;
		recv_idle = 85;
		test_bad_filter();
		test_directed_filters();
		test_random(200);

		send_idle = 85;
		recv_idle = 19;
		test_random(200);

		send_idle = 0;
		recv_idle = 0;
		test_random(30);
		test_config_extremes();
		test_midimage_config();

		drain_pipeline();
		if (fail_count == 0)
			$display("[png_scanline_unfilter_rgba8_top] OK");
		else
			$display("[png_scanline_unfilter_rgba8_top] ERROR");
		$finish;
	end

endmodule
